/* hdl/pbf_pkg.sv */
// ----------------------------------------------------------------------------
// pbf_pkg
// Shared types and constants for the paging block framer.
// ----------------------------------------------------------------------------
package pbf_pkg;

  localparam int ID_W  = 31;
  localparam int SUM_W = 12;

  // register indexes on the configuration port
  localparam logic [1:0] REG_START = 2'd0;
  localparam logic [1:0] REG_STOP  = 2'd1;
  localparam logic [1:0] REG_CR    = 2'd2;

  localparam logic [7:0] START_RST  = 8'h02;
  localparam logic [7:0] STOP_RST   = 8'h03;
  localparam logic [7:0] CR_RST     = 8'h0d;
  localparam logic [7:0] ASCII_ZERO = 8'h30;

  typedef struct packed {
    logic [ID_W-1:0] pager_id;
    logic [7:0]      msg_char;
    logic            has_char;
    logic            last;
  } msg_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
  } blk_t;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] stop_byte;
    logic [7:0] cr_byte;
  } cfg_t;

  // one classified word waiting for the back end
  typedef struct packed {
    logic            need_header;
    logic [ID_W-1:0] pager_id;
    logic [7:0]      msg_char;
    logic            has_char;
    logic            last;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic full;
  } queue_status_t;

endpackage

/* hdl/pbf_front.sv */
// ----------------------------------------------------------------------------
// pbf_front
// Accepts message words, tracks whether a block is open and tags each word
// that must open a new block with a header request.
// ----------------------------------------------------------------------------
module pbf_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  msg_valid,
  output logic                  msg_ready,
  input  pbf_pkg::msg_t         msg,
  input  pbf_pkg::queue_status_t qstat,
  output logic                  push,
  output pbf_pkg::cmd_t         cmd
);
  import pbf_pkg::*;

  logic in_frame;

  assign msg_ready = !qstat.full;
  assign push      = msg_valid && msg_ready;

  always_comb begin
    cmd.need_header = !in_frame;
    cmd.pager_id    = msg.pager_id;
    cmd.msg_char    = msg.msg_char;
    cmd.has_char    = msg.has_char;
    cmd.last        = msg.last;
  end

  // block stays open until a word marked last goes by
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame <= 1'b0;
    end else if (push) begin
      in_frame <= !msg.last;
    end
  end

endmodule

/* hdl/pbf_queue.sv */
// ----------------------------------------------------------------------------
// pbf_queue
// Two-entry queue of classified words between the front and back ends.
// ----------------------------------------------------------------------------
module pbf_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  pbf_pkg::cmd_t          push_cmd,
  input  logic                   pop,
  output pbf_pkg::cmd_t          head,
  output pbf_pkg::queue_status_t qstat
);
  import pbf_pkg::*;

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign head        = entries[rd_ptr];
  assign qstat.valid = (count != 2'd0);
  assign qstat.full  = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* hdl/pbf_back.sv */
// ----------------------------------------------------------------------------
// pbf_back
// Sequences the bytes of a block for the word at the queue head: header with
// shift-add-3 decimal conversion of the pager ID, pass-through character,
// and the closing part with the checksum. Drives the output register.
// ----------------------------------------------------------------------------
module pbf_back #(
  parameter int MAX_ID_DIGITS = 10
) (
  input  logic                   clk,
  input  logic                   rst,
  input  pbf_pkg::cfg_t          cfg,
  input  pbf_pkg::cmd_t          head,
  input  pbf_pkg::queue_status_t qstat,
  output logic                   pop,
  output logic                   blk_valid,
  input  logic                   blk_ready,
  output pbf_pkg::blk_t          blk
);
  import pbf_pkg::*;

  localparam int BCD_W = 4 * MAX_ID_DIGITS;
  localparam int IDX_W = (MAX_ID_DIGITS > 1) ? $clog2(MAX_ID_DIGITS) : 1;
  localparam int CNT_W = $clog2(ID_W);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_START = 4'd1;
  localparam logic [3:0] ST_CONV  = 4'd2;
  localparam logic [3:0] ST_SKIP  = 4'd3;
  localparam logic [3:0] ST_DIGIT = 4'd4;
  localparam logic [3:0] ST_HCR   = 4'd5;
  localparam logic [3:0] ST_CHAR  = 4'd6;
  localparam logic [3:0] ST_LCR   = 4'd7;
  localparam logic [3:0] ST_STOP  = 4'd8;
  localparam logic [3:0] ST_CK2   = 4'd9;
  localparam logic [3:0] ST_CK1   = 4'd10;
  localparam logic [3:0] ST_CK0   = 4'd11;
  localparam logic [3:0] ST_FCR   = 4'd12;

  logic [3:0]       state;
  logic [3:0]       state_next;
  logic [SUM_W-1:0] running_sum;
  logic [ID_W-1:0]  id_sh;
  logic [BCD_W-1:0] bcd;
  logic [BCD_W-1:0] bcd_adj;
  logic [BCD_W-1:0] bcd_shift;
  logic [CNT_W-1:0] bit_cnt;
  logic [IDX_W-1:0] idx;
  logic [3:0]       cur_digit;
  logic             out_free;
  logic             emit;
  logic             emit_end;
  logic             summed;
  logic [7:0]       emit_byte;

  assign out_free  = !blk_valid || blk_ready;
  assign cur_digit = bcd[idx*4 +: 4];

  // add 3 to every digit above 4, then shift in the next ID bit
  always_comb begin
    for (int i = 0; i < MAX_ID_DIGITS; i++) begin
      bcd_adj[i*4 +: 4] = (bcd[i*4 +: 4] > 4'd4) ? bcd[i*4 +: 4] + 4'd3 : bcd[i*4 +: 4];
    end
  end
  assign bcd_shift = {bcd_adj[BCD_W-2:0], id_sh[ID_W-1]};

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    emit_end   = 1'b0;
    summed     = 1'b0;
    emit_byte  = 8'h00;
    pop        = 1'b0;
    case (state)
      ST_IDLE: begin
        if (qstat.valid) begin
          if (head.need_header) begin
            state_next = ST_START;
          end else if (head.has_char) begin
            state_next = ST_CHAR;
          end else if (head.last) begin
            state_next = ST_LCR;
          end else begin
            pop = 1'b1;
          end
        end
      end
      ST_START: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_byte  = cfg.start_byte;
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        if (bit_cnt == CNT_W'(ID_W - 1)) begin
          state_next = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // drop leading zeros, keep at least one digit
        if (cur_digit != 4'd0 || idx == '0) begin
          state_next = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (out_free) begin
          emit      = 1'b1;
          summed    = 1'b1;
          emit_byte = ASCII_ZERO + {4'd0, cur_digit};
          if (idx == '0) begin
            state_next = ST_HCR;
          end
        end
      end
      ST_HCR: begin
        if (out_free) begin
          emit      = 1'b1;
          summed    = 1'b1;
          emit_byte = cfg.cr_byte;
          if (head.has_char) begin
            state_next = ST_CHAR;
          end else if (head.last) begin
            state_next = ST_LCR;
          end else begin
            pop        = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      ST_CHAR: begin
        if (out_free) begin
          emit      = 1'b1;
          summed    = 1'b1;
          emit_byte = head.msg_char;
          if (head.last) begin
            state_next = ST_LCR;
          end else begin
            pop        = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      ST_LCR: begin
        if (out_free) begin
          emit       = 1'b1;
          summed     = 1'b1;
          emit_byte  = cfg.cr_byte;
          state_next = ST_STOP;
        end
      end
      ST_STOP: begin
        if (out_free) begin
          emit       = 1'b1;
          summed     = 1'b1;
          emit_byte  = cfg.stop_byte;
          state_next = ST_CK2;
        end
      end
      ST_CK2: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_byte  = ASCII_ZERO + {4'd0, running_sum[11:8]};
          state_next = ST_CK1;
        end
      end
      ST_CK1: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_byte  = ASCII_ZERO + {4'd0, running_sum[7:4]};
          state_next = ST_CK0;
        end
      end
      ST_CK0: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_byte  = ASCII_ZERO + {4'd0, running_sum[3:0]};
          state_next = ST_FCR;
        end
      end
      ST_FCR: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_end   = 1'b1;
          emit_byte  = cfg.cr_byte;
          pop        = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      blk_valid   <= 1'b0;
      running_sum <= '0;
    end else begin
      state <= state_next;
      if (emit) begin
        blk_valid <= 1'b1;
      end else if (blk_ready) begin
        blk_valid <= 1'b0;
      end
      // restart the checksum with the start byte
      if (state == ST_START && emit) begin
        running_sum <= {4'd0, emit_byte};
      end else if (summed) begin
        running_sum <= running_sum + {4'd0, emit_byte};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      blk.out_byte  <= emit_byte;
      blk.frame_end <= emit_end;
    end
    case (state)
      ST_START: begin
        id_sh   <= head.pager_id;
        bcd     <= '0;
        bit_cnt <= '0;
        idx     <= IDX_W'(MAX_ID_DIGITS - 1);
      end
      ST_CONV: begin
        bcd     <= bcd_shift;
        id_sh   <= id_sh << 1;
        bit_cnt <= bit_cnt + CNT_W'(1);
      end
      ST_SKIP: begin
        if (cur_digit == 4'd0 && idx != '0) begin
          idx <= idx - IDX_W'(1);
        end
      end
      ST_DIGIT: begin
        if (emit) begin
          idx <= idx - IDX_W'(1);
        end
      end
      default: begin
        idx <= idx;
      end
    endcase
  end

endmodule

/* hdl/paging_block_framer.sv */
// ----------------------------------------------------------------------------
// paging_block_framer
// Turns a stream of message words into paging-protocol blocks.
// ----------------------------------------------------------------------------
// Input channel msg_valid/msg_ready/msg carries one word: pager ID, an
// optional character and a last flag. Output channel blk_valid/blk_ready/blk
// carries one byte of the block; frame_end marks the closing CR.
// The first word of a block yields start byte, pager ID in decimal, CR; a
// character word yields the character; a last word yields CR, stop byte,
// three checksum digits and the closing CR.
// A front end classifies words into a two-entry queue; the back end picks up
// each queued word in its idle state, then emits at most one byte per
// cycle from an output register. A header emits the start byte, converts
// the pager ID by shift-add-3, skips leading zeros, then emits the digits
// and the CR. The queue holds up to two words, including the one that the
// back end is working on. Reset clears the queue, the open-block flag, the
// checksum and the output valid flag and restores the default start, stop
// and CR bytes. When the receiver holds blk_ready low the back end stalls
// and the queue fills, then msg_ready drops.
// Configuration writes take effect on the next clock edge.
// ----------------------------------------------------------------------------
module paging_block_framer #(
  parameter int MAX_ID_DIGITS = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [7:0]    cfg_data,
  input  logic          msg_valid,
  output logic          msg_ready,
  input  pbf_pkg::msg_t msg,
  output logic          blk_valid,
  input  logic          blk_ready,
  output pbf_pkg::blk_t blk
);
  import pbf_pkg::*;

  cfg_t          cfg;
  cmd_t          push_cmd;
  cmd_t          head;
  queue_status_t qstat;
  logic          push;
  logic          pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte <= START_RST;
      cfg.stop_byte  <= STOP_RST;
      cfg.cr_byte    <= CR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START: cfg.start_byte <= cfg_data;
        REG_STOP:  cfg.stop_byte  <= cfg_data;
        REG_CR:    cfg.cr_byte    <= cfg_data;
        default:   cfg <= cfg;
      endcase
    end
  end

  pbf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_ready (msg_ready),
    .msg       (msg),
    .qstat     (qstat),
    .push      (push),
    .cmd       (push_cmd)
  );

  pbf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  pbf_back #(
    .MAX_ID_DIGITS (MAX_ID_DIGITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .blk_valid (blk_valid),
    .blk_ready (blk_ready),
    .blk       (blk)
  );

endmodule

/* hdl/pbf_checker.sv */
// ----------------------------------------------------------------------------
// pbf_checker
// Port-level checks for the paging block framer, bound to the top level.
// ----------------------------------------------------------------------------
module pbf_checker (
  input logic          clk,
  input logic          rst,
  input logic          cfg_we,
  input logic [1:0]    cfg_index,
  input logic [7:0]    cfg_data,
  input logic          msg_ready,
  input logic          blk_valid,
  input logic          blk_ready,
  input pbf_pkg::blk_t blk
);
  import pbf_pkg::*;

  logic [7:0] cr_copy;

  // follow the CR register as written on the port
  always_ff @(posedge clk) begin
    if (rst) begin
      cr_copy <= CR_RST;
    end else if (cfg_we && cfg_index == REG_CR) begin
      cr_copy <= cfg_data;
    end
  end

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !blk_valid && msg_ready)
    else $error("output not empty or input not ready after reset");

  a_hold_word: assert property (@(posedge clk) disable iff (rst)
    blk_valid && !blk_ready |=> blk_valid && $stable(blk))
    else $error("stalled output word changed or dropped");

  a_end_is_cr: assert property (@(posedge clk) disable iff (rst)
    blk_valid && blk.frame_end |-> blk.out_byte == cr_copy)
    else $error("block end marked on a byte other than CR");

  a_end_after_ck: assert property (@(posedge clk) disable iff (rst)
    blk_valid && blk_ready && blk.frame_end |=> !(blk_valid && blk.frame_end))
    else $error("two block ends in a row");

endmodule

bind paging_block_framer pbf_checker u_pbf_checker (.*);

/* test/paging_block_framer_test.sv */
// ----------------------------------------------------------------------------
// paging_block_framer_test
// Self-checking bench for the paging block framer. Message words go in on the
// msg channel. A tracker computes every block byte that each accepted word
// must produce: header with the decimal pager ID, pass-through characters,
// and the closing part with its checksum. It compares them, in order, with
// the bytes taken off the blk channel. A directed sequence comes first. Then
// random frames run under three register settings and three idling mixes.
// ----------------------------------------------------------------------------
module paging_block_framer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pbf_pkg::*;

  localparam int         ID_DIGITS = 10;
  localparam int         SETTLE    = 80;
  localparam logic [1:0] REG_NONE  = 2'd3; // unused index, must be ignored

  class frame_tracker;
    logic [7:0]      start_b, stop_b, cr_b;
    bit              open;
    logic [SUM_W-1:0] sum;
    blk_t            due_bytes[$];
    int              mismatches, bytes_matched, blocks_closed;

    function new();
      start_b = START_RST;
      stop_b  = STOP_RST;
      cr_b    = CR_RST;
      open    = 1'b0;
      sum     = '0;
      mismatches = 0;
      bytes_matched = 0;
      blocks_closed = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] data);
      case (idx)
        REG_START: start_b = data;
        REG_STOP:  stop_b  = data;
        REG_CR:    cr_b    = data;
        default: ;
      endcase
    endfunction

    function void push_byte(logic [7:0] b, logic fe, bit summed);
      blk_t e;
      e.out_byte  = b;
      e.frame_end = fe;
      due_bytes.push_back(e);
      if (summed) sum = sum + {4'h0, b};
    endfunction

    function void take_word(msg_t w);
      logic [3:0]      digit [ID_DIGITS];
      logic [ID_W-1:0] rest;
      int              nd;
      if (!open) begin
        sum = '0;
        push_byte(start_b, 1'b0, 1'b1);
        rest = w.pager_id;
        nd = 0;
        // lowest digit first, at most ID_DIGITS of them
        do begin
          digit[nd] = 4'(rest % 10);
          nd++;
          rest = ID_W'(rest / 10);
        end while (rest != 0 && nd < ID_DIGITS);
        while (nd > 0) begin
          nd--;
          push_byte(ASCII_ZERO + {4'h0, digit[nd]}, 1'b0, 1'b1);
        end
        push_byte(cr_b, 1'b0, 1'b1);
        open = 1'b1;
      end
      if (w.has_char) push_byte(w.msg_char, 1'b0, 1'b1);
      if (w.last) begin
        push_byte(cr_b, 1'b0, 1'b1);
        push_byte(stop_b, 1'b0, 1'b1);
        push_byte(ASCII_ZERO + {4'h0, sum[11:8]}, 1'b0, 1'b0);
        push_byte(ASCII_ZERO + {4'h0, sum[7:4]}, 1'b0, 1'b0);
        push_byte(ASCII_ZERO + {4'h0, sum[3:0]}, 1'b0, 1'b0);
        push_byte(cr_b, 1'b1, 1'b0);
        open = 1'b0;
        sum  = '0;
      end
    endfunction

    function void match_byte(blk_t got);
      blk_t want;
      if (due_bytes.size() == 0) begin
        $error("unexpected block byte: out_byte %h frame_end %b", got.out_byte, got.frame_end);
        mismatches++;
        return;
      end
      want = due_bytes.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
        mismatches++;
      end
      if (got.frame_end !== want.frame_end) begin
        $error("frame_end: expected %b, got %b", want.frame_end, got.frame_end);
        mismatches++;
      end
      bytes_matched++;
      if (want.frame_end) blocks_closed++;
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;
  logic       msg_valid;
  logic       msg_ready;
  msg_t       msg;
  logic       blk_valid;
  logic       blk_ready;
  blk_t       blk;

  frame_tracker tracker = new();
  int send_idle = 0;
  int recv_idle = 0;
  int words_sent = 0;
  int settings_used = 1;

  paging_block_framer #(.MAX_ID_DIGITS(ID_DIGITS)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .msg_valid (msg_valid),
    .msg_ready (msg_ready),
    .msg       (msg),
    .blk_valid (blk_valid),
    .blk_ready (blk_ready),
    .blk       (blk)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // receiver: stall at random, sample at the rising edge
  initial begin
    blk_ready = 1'b0;
    forever begin
      @(negedge clk);
      blk_ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst && blk_valid && blk_ready) tracker.match_byte(blk);
  end

  function automatic msg_t mk(logic [ID_W-1:0] id, logic [7:0] ch, logic has, logic fin);
    msg_t w;
    w.pager_id = id;
    w.msg_char = ch;
    w.has_char = has;
    w.last     = fin;
    return w;
  endfunction

  // called and returns at a falling edge
  task automatic send_word(input msg_t w);
    while ($urandom_range(0, 99) < send_idle) begin
      msg_valid <= 1'b0;
      @(negedge clk);
    end
    msg_valid <= 1'b1;
    msg       <= w;
    do @(posedge clk); while (!msg_ready);
    tracker.take_word(w);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    msg_valid <= 1'b0;
    while (tracker.due_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  // write all three registers plus the unused index; block must be idle
  task automatic program_regs(input logic [7:0] s, input logic [7:0] p, input logic [7:0] c);
    cfg_we    <= 1'b1;
    cfg_index <= REG_START;
    cfg_data  <= s;
    tracker.set_reg(REG_START, s);
    @(negedge clk);
    cfg_index <= REG_STOP;
    cfg_data  <= p;
    tracker.set_reg(REG_STOP, p);
    @(negedge clk);
    cfg_index <= REG_CR;
    cfg_data  <= c;
    tracker.set_reg(REG_CR, c);
    @(negedge clk);
    cfg_index <= REG_NONE;
    cfg_data  <= 8'($urandom);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    settings_used++;
  endtask

  task automatic random_frames(input int n_words);
    int              taken;
    int              len;
    logic [ID_W-1:0] id;
    msg_t            w;
    taken = 0;
    while (taken < n_words) begin
      case ($urandom_range(0, 3))
        0:       id = ID_W'($urandom_range(0, 9));
        1:       id = ID_W'($urandom_range(0, 99999));
        default: id = ID_W'($urandom);
      endcase
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        // pager_id on later words is noise and must be ignored
        w.pager_id = (i == 0) ? id : ID_W'($urandom);
        w.msg_char = 8'($urandom);
        w.has_char = ($urandom_range(0, 7) != 0);
        w.last     = (i == len - 1);
        send_word(w);
        if (i == 0 || w.has_char || w.last) taken++;
      end
    end
  endtask

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = REG_START;
    cfg_data  = 8'h00;
    msg_valid = 1'b0;
    msg       = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed words under the reset register values
    send_idle = 10;
    recv_idle = 30;
    send_word(mk(31'd0, "A", 1'b1, 1'b0));
    send_word(mk(31'h2AAAAAAA, 8'h00, 1'b1, 1'b0));
    send_word(mk(31'h55555555, 8'hFF, 1'b1, 1'b0));
    send_word(mk(31'd77, 8'h00, 1'b0, 1'b0));
    send_word(mk(31'd88, 8'h7E, 1'b0, 1'b1));
    send_word(mk(31'h7FFFFFFF, 8'h55, 1'b0, 1'b1));
    send_word(mk(31'd12345, 8'h00, 1'b0, 1'b0));
    send_word(mk(31'd0, 8'hAA, 1'b1, 1'b1));
    send_word(mk(31'd1, "Z", 1'b1, 1'b1));
    send_word(mk(31'd9, "9", 1'b1, 1'b1));
    send_word(mk(31'd10, "a", 1'b1, 1'b1));
    send_word(mk(31'd999999999, 8'h80, 1'b1, 1'b1));
    send_word(mk(31'd1000000000, 8'h01, 1'b1, 1'b1));
    send_word(mk(31'h40000000, 8'h7F, 1'b0, 1'b1));
    // leave a frame open, then change registers before finishing it
    send_word(mk(31'd7, "x", 1'b1, 1'b0));
    drain();
    program_regs(START_RST, 8'h04, 8'h00);
    send_word(mk(31'd0, "y", 1'b1, 1'b0));
    send_word(mk(31'd0, 8'h00, 1'b0, 1'b1));
    drain();

    program_regs(8'hFF, 8'h00, 8'hFF);
    send_idle = 21;
    recv_idle = 79;
    random_frames(46);
    drain();

    program_regs(8'h00, 8'hFF, 8'h00);
    send_idle = 79;
    recv_idle = 21;
    random_frames(46);
    drain();

    program_regs(START_RST, STOP_RST, CR_RST);
    send_idle = 0;
    recv_idle = 0;
    random_frames(46);
    drain();

    $display("Framed %0d message words into %0d blocks under %0d register settings;",
             words_sent, tracker.blocks_closed, settings_used);
    $display("compared %0d block bytes, %0d mismatches.",
             tracker.bytes_matched, tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/pbf_pkg.sv
hdl/pbf_front.sv
hdl/pbf_queue.sv
hdl/pbf_back.sv
hdl/paging_block_framer.sv
hdl/pbf_checker.sv
test/paging_block_framer_test.sv
